// File: design/vpa_pkg.sv
// Package with the types, constants and codes shared by the allocator files.
package vpa_pkg;

   localparam int MAX_SEGMENTS = 32;
   localparam int ADDR_BITS    = 16;
   localparam int SEG_BITS     = $clog2(MAX_SEGMENTS);
   localparam int CNT_BITS     = SEG_BITS + 1;
   localparam int SIZE_BITS    = 16;
   localparam int OWNER_BITS   = 16;

   localparam logic [SIZE_BITS-1:0] MEMORY_SIZE_RESET = 16'd1024;

   // Action codes.
   localparam logic [1:0] ACT_ALLOC = 2'd0;
   localparam logic [1:0] ACT_FREE  = 2'd1;
   localparam logic [1:0] ACT_INIT  = 2'd2;

   // Fit policies.
   localparam logic [1:0] FIT_FIRST = 2'd0;
   localparam logic [1:0] FIT_BEST  = 2'd1;
   localparam logic [1:0] FIT_WORST = 2'd2;

   // Status codes.
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD_SIZE  = 3'd1;
   localparam logic [2:0] ST_NO_FIT    = 3'd2;
   localparam logic [2:0] ST_NO_OWNER  = 3'd3;
   localparam logic [2:0] ST_FULL      = 3'd4;

   // Configuration register indexes.
   localparam logic [0:0] CSR_MEMORY_SIZE = 1'd0;
   localparam logic [0:0] CSR_FIT_POLICY  = 1'd1;

   typedef struct packed {
      logic [1:0]            action;
      logic [SIZE_BITS-1:0]  req_size;
      logic [OWNER_BITS-1:0] owner_id;
   } req_type;

   typedef struct packed {
      logic [2:0]           status;
      logic [ADDR_BITS-1:0] address;
   } rsp_type;

endpackage

// File: design/variable_partition_allocator_core.sv
// Variable-partition memory allocator: sequencer over free and allocation tables.
//
// Usage: requests arrive on the req_ channel (valid/ready) as a req_type item:
// allocate, free by owner, or reinitialize. Each item yields exactly one
// rsp_type item on the rsp_ channel (status and address). Two configuration
// registers (memory_size, fit_policy) are written over the csr_ channel,
// index 0 and 1; they are always ready.
// One item is worked on at a time by a small sequencer that visits one
// table entry per cycle. Allocate runs a fit scan, a slot scan, a carve and,
// when the segment is used up, a delete shift. Free visits all MAX_SEGMENTS
// slots and, for each released range, scans and shifts the free table.
// req_ready is low while an item is at work.
// The result stays in an output register until rsp_ready takes it; a new
// item is accepted while that result still waits.
// Reset (synchronous, active high) loads memory_size 1024, fit_policy 0,
// one free segment of 1024 units at address 0 and no allocations.
module variable_partition_allocator_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  vpa_pkg::req_type      req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output vpa_pkg::rsp_type      rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [0:0]            csr_index,
   input  logic [15:0]           csr_data
);
   import vpa_pkg::*;

   typedef enum logic [11:0] {
      S_IDLE    = 12'b000000000001,
      S_FIT     = 12'b000000000010,
      S_SLOT    = 12'b000000000100,
      S_CARVE   = 12'b000000001000,
      S_DSHIFT  = 12'b000000010000,
      S_FSCAN   = 12'b000000100000,
      S_IFIND   = 12'b000001000000,
      S_IPREV   = 12'b000010000000,
      S_IMERGE  = 12'b000100000000,
      S_ISHIFT  = 12'b001000000000,
      S_DONE    = 12'b010000000000,
      S_WAIT    = 12'b100000000000
   } state_type;

   // Tables held in flip-flops; alloc_valid has reset, others are payload.
   logic [ADDR_BITS-1:0]  fs_ff [MAX_SEGMENTS];
   logic [ADDR_BITS-1:0]  fl_ff [MAX_SEGMENTS];
   logic [OWNER_BITS-1:0] ao_ff [MAX_SEGMENTS];
   logic [ADDR_BITS-1:0]  as_ff [MAX_SEGMENTS];
   logic [SIZE_BITS-1:0]  al_ff [MAX_SEGMENTS];
   logic [MAX_SEGMENTS-1:0] av_ff;

   state_type             state_ff;
   logic [CNT_BITS-1:0]   fcnt_ff;
   logic [CNT_BITS-1:0]   idx_ff;
   logic [CNT_BITS-1:0]   slot_ff;
   logic [CNT_BITS-1:0]   pick_ff;
   logic                  found_ff;
   logic                  matched_ff;
   logic                  full_ff;
   req_type               req_ff;
   logic [SIZE_BITS-1:0]  msize_ff;
   logic [1:0]            policy_ff;
   logic [ADDR_BITS-1:0]  ins_s_ff;
   logic [ADDR_BITS-1:0]  ins_l_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff;
   logic [2:0]            st_ff;
   logic [ADDR_BITS-1:0]  addr_ff;

   // Shared arithmetic on the entry picked by idx_ff.
   logic [SEG_BITS-1:0]   ix;
   logic [SEG_BITS-1:0]   ixm1;
   logic [ADDR_BITS-1:0]  cur_s;
   logic [ADDR_BITS-1:0]  cur_l;
   logic [ADDR_BITS-1:0]  prev_end;
   logic                  better;
   logic                  bad_size;
   logic                  rsp_load;

   assign ix   = idx_ff[SEG_BITS-1:0];
   assign ixm1 = ix - 1'b1;
   assign cur_s = fs_ff[ix];
   assign cur_l = fl_ff[ix];
   assign prev_end = fs_ff[ixm1] + fl_ff[ixm1];

   // An allocate of zero units or more than memory_size is refused at once.
   assign bad_size = (req_data.req_size == '0) || (req_data.req_size > msize_ff);

   // The finished result moves into the output register once it is free.
   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      case (policy_ff)
         FIT_FIRST: better = !found_ff;
         FIT_BEST:  better = !found_ff || (cur_l < fl_ff[pick_ff[SEG_BITS-1:0]]);
         FIT_WORST: better = !found_ff || (cur_l > fl_ff[pick_ff[SEG_BITS-1:0]]);
         default:   better = 1'b0;
      endcase
   end

   assign req_ready = (state_ff == S_IDLE) || (state_ff == S_WAIT && !rsp_valid_ff);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Output valid flag: set on load, cleared when the receiver takes the item.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Sequencer and table updates.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fcnt_ff      <= CNT_BITS'(1);
         av_ff        <= '0;
         msize_ff     <= MEMORY_SIZE_RESET;
         policy_ff    <= FIT_FIRST;
         fs_ff[0]     <= '0;
         fl_ff[0]     <= ADDR_BITS'(MEMORY_SIZE_RESET);
      end else begin
         if (csr_valid) begin
            if (csr_index == CSR_MEMORY_SIZE) msize_ff <= csr_data;
            else                              policy_ff <= csr_data[1:0];
         end

         case (state_ff)
            S_IDLE, S_WAIT: begin
               if (req_valid && req_ready) begin
                  req_ff     <= req_data;
                  idx_ff     <= '0;
                  found_ff   <= 1'b0;
                  matched_ff <= 1'b0;
                  full_ff    <= 1'b0;
                  st_ff      <= (req_data.action == ACT_ALLOC && bad_size) ? ST_BAD_SIZE
                                                                          : ST_OK;
                  addr_ff    <= '0;
                  case (req_data.action)
                     ACT_ALLOC: state_ff <= bad_size ? S_DONE : S_FIT;
                     ACT_FREE: state_ff <= S_FSCAN;
                     ACT_INIT: begin
                        av_ff    <= '0;
                        fs_ff[0] <= '0;
                        fl_ff[0] <= ADDR_BITS'(msize_ff);
                        fcnt_ff  <= (msize_ff != '0) ? CNT_BITS'(1) : '0;
                        state_ff <= S_DONE;
                     end
                     default: state_ff <= S_DONE;
                  endcase
               end else if (state_ff == S_WAIT && !rsp_valid_ff) begin
                  state_ff <= S_IDLE;
               end
            end

            // One free entry per cycle for the fit choice.
            S_FIT: begin
               if (idx_ff >= fcnt_ff) begin
                  idx_ff <= '0;
                  if (!found_ff) begin
                     st_ff    <= ST_NO_FIT;
                     state_ff <= S_DONE;
                  end else begin
                     state_ff <= S_SLOT;
                  end
               end else begin
                  if (cur_l >= ADDR_BITS'(req_ff.req_size) && better) begin
                     pick_ff  <= idx_ff;
                     found_ff <= 1'b1;
                  end
                  idx_ff <= idx_ff + 1'b1;
               end
            end

            // Lowest free allocation slot.
            S_SLOT: begin
               if (idx_ff == CNT_BITS'(MAX_SEGMENTS)) begin
                  st_ff    <= ST_FULL;
                  state_ff <= S_DONE;
               end else if (!av_ff[ix]) begin
                  slot_ff  <= idx_ff;
                  state_ff <= S_CARVE;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end

            S_CARVE: begin
               av_ff[slot_ff[SEG_BITS-1:0]] <= 1'b1;
               ao_ff[slot_ff[SEG_BITS-1:0]] <= req_ff.owner_id;
               as_ff[slot_ff[SEG_BITS-1:0]] <= fs_ff[pick_ff[SEG_BITS-1:0]];
               al_ff[slot_ff[SEG_BITS-1:0]] <= req_ff.req_size;
               addr_ff <= fs_ff[pick_ff[SEG_BITS-1:0]];
               fs_ff[pick_ff[SEG_BITS-1:0]] <= fs_ff[pick_ff[SEG_BITS-1:0]]
                                               + ADDR_BITS'(req_ff.req_size);
               fl_ff[pick_ff[SEG_BITS-1:0]] <= fl_ff[pick_ff[SEG_BITS-1:0]]
                                               - ADDR_BITS'(req_ff.req_size);
               if (fl_ff[pick_ff[SEG_BITS-1:0]] == ADDR_BITS'(req_ff.req_size)) begin
                  idx_ff   <= pick_ff;
                  state_ff <= S_DSHIFT;
               end else begin
                  state_ff <= S_DONE;
               end
            end

            // Delete shift: move entry idx+1 down one entry per cycle.
            S_DSHIFT: begin
               if (idx_ff + 1'b1 < fcnt_ff) begin
                  fs_ff[ix] <= fs_ff[SEG_BITS'(idx_ff + 1'b1)];
                  fl_ff[ix] <= fl_ff[SEG_BITS'(idx_ff + 1'b1)];
                  idx_ff    <= idx_ff + 1'b1;
               end else begin
                  fcnt_ff <= fcnt_ff - 1'b1;
                  if (req_ff.action == ACT_FREE) begin
                     av_ff[slot_ff[SEG_BITS-1:0]] <= 1'b0;
                     idx_ff   <= slot_ff + 1'b1;
                     state_ff <= S_FSCAN;
                  end else begin
                     state_ff <= S_DONE;
                  end
               end
            end

            // Walk allocation slots for the owner.
            S_FSCAN: begin
               if (idx_ff == CNT_BITS'(MAX_SEGMENTS)) begin
                  st_ff <= !matched_ff ? ST_NO_OWNER : (full_ff ? ST_FULL : ST_OK);
                  state_ff <= S_DONE;
               end else if (av_ff[ix] && ao_ff[ix] == req_ff.owner_id) begin
                  matched_ff <= 1'b1;
                  slot_ff    <= idx_ff;
                  ins_s_ff   <= as_ff[ix];
                  ins_l_ff   <= ADDR_BITS'(al_ff[ix]);
                  idx_ff     <= '0;
                  state_ff   <= S_IFIND;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end

            // Insert position: first entry whose start exceeds the range.
            S_IFIND: begin
               if (idx_ff < fcnt_ff && cur_s <= ins_s_ff) idx_ff <= idx_ff + 1'b1;
               else state_ff <= S_IPREV;
            end

            S_IPREV: begin
               pick_ff  <= idx_ff;
               found_ff <= (idx_ff != '0) && (prev_end == ins_s_ff);
               state_ff <= S_IMERGE;
            end

            S_IMERGE: begin
               if (found_ff && idx_ff < fcnt_ff
                   && (ins_s_ff + ins_l_ff) == cur_s) begin
                  fl_ff[ixm1] <= fl_ff[ixm1] + ins_l_ff + cur_l;
                  state_ff    <= S_DSHIFT;
               end else if (found_ff) begin
                  fl_ff[ixm1] <= fl_ff[ixm1] + ins_l_ff;
                  av_ff[slot_ff[SEG_BITS-1:0]] <= 1'b0;
                  idx_ff   <= slot_ff + 1'b1;
                  state_ff <= S_FSCAN;
               end else if (idx_ff < fcnt_ff && (ins_s_ff + ins_l_ff) == cur_s) begin
                  fs_ff[ix] <= ins_s_ff;
                  fl_ff[ix] <= cur_l + ins_l_ff;
                  av_ff[slot_ff[SEG_BITS-1:0]] <= 1'b0;
                  idx_ff   <= slot_ff + 1'b1;
                  state_ff <= S_FSCAN;
               end else if (fcnt_ff == CNT_BITS'(MAX_SEGMENTS)) begin
                  full_ff  <= 1'b1;
                  idx_ff   <= slot_ff + 1'b1;
                  state_ff <= S_FSCAN;
               end else begin
                  idx_ff   <= fcnt_ff;
                  state_ff <= S_ISHIFT;
               end
            end

            // Insert shift: move entries up from the top, one per cycle.
            S_ISHIFT: begin
               if (idx_ff > pick_ff) begin
                  fs_ff[ix] <= fs_ff[ixm1];
                  fl_ff[ix] <= fl_ff[ixm1];
                  idx_ff    <= idx_ff - 1'b1;
               end else begin
                  fs_ff[ix] <= ins_s_ff;
                  fl_ff[ix] <= ins_l_ff;
                  fcnt_ff   <= fcnt_ff + 1'b1;
                  av_ff[slot_ff[SEG_BITS-1:0]] <= 1'b0;
                  idx_ff   <= slot_ff + 1'b1;
                  state_ff <= S_FSCAN;
               end
            end

            // Hand the result to the output register once it is free.
            S_DONE: begin
               if (rsp_load) begin
                  rsp_ff.status  <= st_ff;
                  rsp_ff.address <= (st_ff == ST_OK) ? addr_ff : '0;
                  state_ff       <= S_IDLE;
               end
            end

            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // The free table never holds more entries than it has room for.
   a_fcnt_range: assert property (@(posedge clock) disable iff (reset)
      fcnt_ff <= CNT_BITS'(MAX_SEGMENTS)) else $error("free count overflow");

   // Only one item is worked on at a time.
   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE && state_ff != S_WAIT) |-> !req_ready)
      else $error("ready while busy");

   // A result appears only from the done step.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("result from wrong step");

   // A waiting result is not overwritten.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> $stable(rsp_ff))
      else $error("result changed while stalled");

endmodule

// File: test/vpa_result_checker.sv
// Checker for the allocator: predicts each response and compares it with the block's output.
`timescale 1ns / 100ps

module vpa_result_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  vpa_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  vpa_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   input  logic             csr_ready,
   input  logic [0:0]       csr_index,
   input  logic [15:0]      csr_data,
   output int               fail_count,
   output int               pending
);
   import vpa_pkg::*;

   // Shadow copy of the configuration and of both tables.
   logic [SIZE_BITS-1:0]  mem_units;
   logic [1:0]            policy;
   logic [ADDR_BITS-1:0]  seg_start [MAX_SEGMENTS];
   logic [ADDR_BITS-1:0]  seg_len   [MAX_SEGMENTS];
   int                    seg_count;
   logic [OWNER_BITS-1:0] slot_owner [MAX_SEGMENTS];
   logic [ADDR_BITS-1:0]  slot_start [MAX_SEGMENTS];
   logic [SIZE_BITS-1:0]  slot_len   [MAX_SEGMENTS];
   bit                    slot_used  [MAX_SEGMENTS];

   rsp_type expected_rsp [$];

   // One free segment spanning memory, no allocations.
   function automatic void rebuild_tables();
      for (int i = 0; i < MAX_SEGMENTS; i++) slot_used[i] = 1'b0;
      seg_start[0] = '0;
      seg_len[0]   = mem_units;
      seg_count    = (mem_units != 0) ? 1 : 0;
   endfunction

   function automatic void remove_segment(int k);
      for (int i = k; i + 1 < seg_count; i++) begin
         seg_start[i] = seg_start[i+1];
         seg_len[i]   = seg_len[i+1];
      end
      if (seg_count > 0) seg_count--;
   endfunction

   // Puts a released range back into the sorted free table, merging with
   // neighbors it touches. Returns zero when a new entry is needed but none is left.
   function automatic bit merge_range(logic [ADDR_BITS-1:0] s, logic [ADDR_BITS-1:0] len);
      int                   p;
      bit                   join_prev;
      bit                   join_next;
      logic [ADDR_BITS-1:0] prev_end;
      logic [ADDR_BITS-1:0] range_end;
      p = 0;
      while (p < seg_count && seg_start[p] <= s) p++;
      range_end = s + len;
      join_prev = 1'b0;
      if (p > 0) begin
         prev_end  = seg_start[p-1] + seg_len[p-1];
         join_prev = (prev_end == s);
      end
      join_next = (p < seg_count) && (range_end == seg_start[p]);
      if (join_prev && join_next) begin
         seg_len[p-1] = seg_len[p-1] + len + seg_len[p];
         remove_segment(p);
      end else if (join_prev) begin
         seg_len[p-1] = seg_len[p-1] + len;
      end else if (join_next) begin
         seg_start[p] = s;
         seg_len[p]   = seg_len[p] + len;
      end else begin
         if (seg_count >= MAX_SEGMENTS) return 1'b0;
         for (int i = seg_count; i > p; i--) begin
            seg_start[i] = seg_start[i-1];
            seg_len[i]   = seg_len[i-1];
         end
         seg_start[p] = s;
         seg_len[p]   = len;
         seg_count++;
      end
      return 1'b1;
   endfunction

   // Picks a segment by policy, takes the lowest free slot and carves the front.
   function automatic logic [2:0] carve_allocation(logic [SIZE_BITS-1:0] size,
                                                   logic [OWNER_BITS-1:0] owner,
                                                   output logic [ADDR_BITS-1:0] addr);
      int pick;
      int slot;
      bit found;
      bit have_slot;
      pick      = 0;
      slot      = 0;
      found     = 1'b0;
      have_slot = 1'b0;
      addr      = '0;
      if (size == 0 || size > mem_units) return ST_BAD_SIZE;
      for (int i = 0; i < seg_count; i++) begin
         if (seg_len[i] >= size) begin
            case (policy)
               FIT_FIRST: begin
                  if (!found) begin pick = i; found = 1'b1; end
               end
               FIT_BEST: begin
                  if (!found || seg_len[i] < seg_len[pick]) begin pick = i; found = 1'b1; end
               end
               FIT_WORST: begin
                  if (!found || seg_len[i] > seg_len[pick]) begin pick = i; found = 1'b1; end
               end
               default: ;
            endcase
         end
      end
      if (!found) return ST_NO_FIT;
      for (int i = 0; i < MAX_SEGMENTS && !have_slot; i++) begin
         if (!slot_used[i]) begin slot = i; have_slot = 1'b1; end
      end
      if (!have_slot) return ST_FULL;
      slot_used[slot]  = 1'b1;
      slot_owner[slot] = owner;
      slot_start[slot] = seg_start[pick];
      slot_len[slot]   = size;
      addr             = seg_start[pick];
      seg_start[pick]  = seg_start[pick] + size;
      seg_len[pick]    = seg_len[pick] - size;
      if (seg_len[pick] == 0) remove_segment(pick);
      return ST_OK;
   endfunction

   // Releases every allocation of one owner.
   function automatic logic [2:0] release_owner(logic [OWNER_BITS-1:0] owner);
      bit matched;
      bit full;
      matched = 1'b0;
      full    = 1'b0;
      for (int i = 0; i < MAX_SEGMENTS; i++) begin
         if (slot_used[i] && slot_owner[i] == owner) begin
            matched = 1'b1;
            if (merge_range(slot_start[i], slot_len[i])) slot_used[i] = 1'b0;
            else full = 1'b1;
         end
      end
      if (!matched) return ST_NO_OWNER;
      return full ? ST_FULL : ST_OK;
   endfunction

   function automatic rsp_type predict_response(req_type item);
      rsp_type r;
      r = '0;
      case (item.action)
         ACT_ALLOC: r.status = carve_allocation(item.req_size, item.owner_id, r.address);
         ACT_FREE:  r.status = release_owner(item.owner_id);
         ACT_INIT:  rebuild_tables();
         default:   ;
      endcase
      return r;
   endfunction

   // Responses are checked before the new item is predicted in the same cycle.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         mem_units  = MEMORY_SIZE_RESET;
         policy     = FIT_FIRST;
         rebuild_tables();
         expected_rsp.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               $display("%0t: response with none expected, actual %p", $time, rsp_data);
               fail_count++;
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_data.status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d", $time, want.status,
                           rsp_data.status);
                  fail_count++;
               end
               if (rsp_data.address !== want.address) begin
                  $display("%0t: address expected %0d actual %0d", $time, want.address,
                           rsp_data.address);
                  fail_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_MEMORY_SIZE) mem_units = csr_data;
            else policy = csr_data[1:0];
         end
         if (req_valid && req_ready) expected_rsp.push_back(predict_response(req_data));
      end
      pending = expected_rsp.size();
   end

endmodule

// File: test/tb_variable_partition_allocator_core.sv
// Testbench top for the allocator: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 100ps

module tb_variable_partition_allocator_core;
   import vpa_pkg::*;

   localparam logic [1:0] ACT_NONE   = 2'd3;
   localparam logic [1:0] FIT_NONE   = 2'd3;
   localparam int         IDLE_LIMIT = 20000;
   localparam int         HOLD_OFF   = 400;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [0:0]  csr_index;
   logic [15:0] csr_data;
   int          fail_count;
   int          pending;
   int          idle_cycles;
   bit          quiet;
   bit          hold_rsp;

   variable_partition_allocator_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   vpa_result_checker checker_inst (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data), .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Mostly short gaps, a few long ones; none at all during quiet stretches.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Receiver: random stalls, plus one long hold-off on request.
   initial begin
      int g;
      rsp_ready = 1'b0;
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF) @(posedge clock);
            hold_rsp = 1'b0;
         end
         g = pick_gap();
         if (g > 0) begin
            rsp_ready <= 1'b0;
            repeat (g) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   // Watchdog on cycles in which no channel moves anything.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("variable_partition_allocator_core regression: fail");
            $finish;
         end
      end
   end

   task automatic send_item(logic [1:0] act, logic [15:0] size, logic [15:0] owner);
      int g;
      g = pick_gap();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{action: act, req_size: size, owner_id: owner};
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic write_csr(logic [0:0] index, logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Lets the checker record the last accepted item before its count is read.
   task automatic wait_idle();
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Mostly allocations of small sizes against a few owners so the tables fill.
   function automatic req_type random_item(logic [15:0] mem);
      req_type it;
      int      r;
      int      cap;
      r  = $urandom_range(0, 99);
      it.owner_id = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
      cap = (mem > 24) ? mem / 24 : 1;
      it.req_size = 16'($urandom_range(1, cap));
      if (r < 58) begin
         it.action = ACT_ALLOC;
         r = $urandom_range(0, 99);
         if (r < 3) it.req_size = '0;
         else if (r < 6 && mem < 16'hFFFF) it.req_size = 16'($urandom_range(mem + 1, 65535));
         else if (r < 9) it.req_size = mem;
         else if (r < 12) it.req_size = 16'($urandom);
      end else if (r < 95) begin
         it.action = ACT_FREE;
      end else if (r < 98) begin
         it.action = ACT_INIT;
      end else begin
         it.action   = ACT_NONE;
         it.req_size = 16'($urandom);
      end
      return it;
   endfunction

   task automatic run_phase(logic [15:0] mem, logic [1:0] pol, int count, bit stall);
      req_type it;
      wait_idle();
      write_csr(CSR_MEMORY_SIZE, mem);
      write_csr(CSR_FIT_POLICY, {14'd0, pol});
      if (stall) hold_rsp = 1'b1;
      repeat (count) begin
         it = random_item(mem);
         send_item(it.action, it.req_size, it.owner_id);
      end
      req_valid <= 1'b0;
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data  = '0;
      quiet     = 1'b0;
      hold_rsp  = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: size limits, whole-memory grab, absent owner, unknown action.
      send_item(ACT_ALLOC, 16'd0, 16'd1);
      send_item(ACT_ALLOC, 16'd1025, 16'd1);
      send_item(ACT_ALLOC, 16'hFFFF, 16'd1);
      send_item(ACT_ALLOC, 16'd1024, 16'hFFFF);
      send_item(ACT_ALLOC, 16'd1, 16'd2);
      send_item(ACT_FREE, 16'd0, 16'd0);
      send_item(ACT_FREE, 16'hFFFF, 16'hFFFF);
      send_item(ACT_NONE, 16'hFFFF, 16'hFFFF);
      send_item(ACT_INIT, 16'd0, 16'd0);
      // Fill every allocation slot, then one more to hit the full table.
      for (int k = 0; k < MAX_SEGMENTS + 1; k++) send_item(ACT_ALLOC, 16'd1, 16'(k));
      send_item(ACT_FREE, 16'd0, 16'd5);
      send_item(ACT_FREE, 16'd0, 16'd6);
      send_item(ACT_ALLOC, 16'd2, 16'd9);
      req_valid <= 1'b0;

      // Random phases over several settings, extremes included.
      run_phase(16'd1024, FIT_FIRST, 150, 1'b0);
      run_phase(16'd1024, FIT_BEST, 150, 1'b1);
      run_phase(16'd1024, FIT_WORST, 150, 1'b0);
      quiet = 1'b1;
      run_phase(16'hFFFF, FIT_FIRST, 100, 1'b0);
      quiet = 1'b0;
      run_phase(16'd40, FIT_BEST, 100, 1'b0);
      run_phase(16'd1, FIT_WORST, 40, 1'b0);
      run_phase(16'd300, FIT_NONE, 40, 1'b0);
      run_phase(16'd200, FIT_WORST, 120, 1'b0);
      run_phase(16'd2000, FIT_FIRST, 150, 1'b1);

      wait_idle();
      repeat (50) @(posedge clock);
      if (fail_count == 0) begin
         $display("variable_partition_allocator_core regression: pass");
      end else begin
         $display("variable_partition_allocator_core regression: fail");
      end
      $finish;
   end

endmodule

// File: files.f
design/vpa_pkg.sv
design/variable_partition_allocator_core.sv
test/vpa_result_checker.sv
test/tb_variable_partition_allocator_core.sv
